// File: design/suv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suv_pkg
// Shared types and constants of the strict UTF-8 stream validator.
// ----------------------------------------------------------------------------
package suv_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned RES_OFF_BITS    = 32;
  localparam int unsigned CP_BITS         = 21;

  // Smallest legal code point for each continuation count, the surrogate range and the largest code point
  localparam logic [CP_BITS-1:0] MIN_CP_2B   = 21'h000080;
  localparam logic [CP_BITS-1:0] MIN_CP_3B   = 21'h000800;
  localparam logic [CP_BITS-1:0] MIN_CP_4B   = 21'h010000;
  localparam logic [CP_BITS-1:0] SURR_LO     = 21'h00D800;
  localparam logic [CP_BITS-1:0] SURR_HI     = 21'h00DFFF;
  localparam logic [CP_BITS-1:0] MAX_CP      = 21'h10FFFF;

  // Continuation counts of an open sequence
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_2B   = 2'd1;
  localparam logic [1:0] SEQ_3B   = 2'd2;
  localparam logic [1:0] SEQ_4B   = 2'd3;

  localparam logic [1:0] CONT_TAG = 2'b10;

  // Narrow per-sequence state
  typedef struct packed {
    logic [1:0]         need;      // continuation bytes still to come
    logic [1:0]         seq_len;   // continuation count of open sequence
    logic [CP_BITS-1:0] cp;        // code point being assembled
    logic               tent_err;  // bad continuation seen, not yet final
    logic               err;       // verdict settled as invalid
  } suv_seq_t;

  localparam suv_seq_t SEQ_RESET = '{need: SEQ_NONE, seq_len: SEQ_NONE,
                                     cp: '0, tent_err: 1'b0, err: 1'b0};

endpackage

// File: design/suv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suv_step
// Single-byte decode: next validator state and the verdict on a last byte.
// ----------------------------------------------------------------------------
module suv_step import suv_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic [7:0]             data_byte,
  input  logic                   last,
  input  suv_seq_t               seq,
  input  logic [OFFSET_BITS-1:0] byte_count,
  input  logic [OFFSET_BITS-1:0] lead_pos,
  input  logic [OFFSET_BITS-1:0] err_pos,
  output suv_seq_t               seq_nxt,
  output logic [OFFSET_BITS-1:0] byte_count_nxt,
  output logic [OFFSET_BITS-1:0] lead_pos_nxt,
  output logic [OFFSET_BITS-1:0] err_pos_nxt,
  output logic                   res_ok,
  output logic [RES_OFF_BITS-1:0] res_offset
);

  suv_seq_t               s;
  logic [OFFSET_BITS-1:0] lp;
  logic [OFFSET_BITS-1:0] ep;
  logic [CP_BITS-1:0]     cp_n;
  logic [1:0]             need_n;
  logic                   bad_cp;
  logic [OFFSET_BITS+RES_OFF_BITS-1:0] ep_ext;

  assign cp_n   = {seq.cp[CP_BITS-7:0], data_byte[5:0]};
  assign need_n = seq.need - 2'd1;

  always_comb begin
    bad_cp = 1'b0;
    unique case (seq.seq_len)
      SEQ_2B:  bad_cp = (cp_n < MIN_CP_2B);
      SEQ_3B:  bad_cp = (cp_n < MIN_CP_3B);
      SEQ_4B:  bad_cp = (cp_n < MIN_CP_4B);
      default: bad_cp = 1'b0;
    endcase
    if ((cp_n >= SURR_LO && cp_n <= SURR_HI) || cp_n > MAX_CP) begin
      bad_cp = 1'b1;
    end
  end

  always_comb begin
    s  = seq;
    lp = lead_pos;
    ep = err_pos;
    if (!seq.err) begin
      if (seq.need == SEQ_NONE) begin
        priority if (!data_byte[7]) begin
          s = seq;
        end else if (data_byte[7:5] == 3'b110) begin
          s.need = SEQ_2B; s.seq_len = SEQ_2B;
          s.cp = {{(CP_BITS-5){1'b0}}, data_byte[4:0]};
          s.tent_err = 1'b0; lp = byte_count;
        end else if (data_byte[7:4] == 4'b1110) begin
          s.need = SEQ_3B; s.seq_len = SEQ_3B;
          s.cp = {{(CP_BITS-4){1'b0}}, data_byte[3:0]};
          s.tent_err = 1'b0; lp = byte_count;
        end else if (data_byte[7:3] == 5'b11110) begin
          s.need = SEQ_4B; s.seq_len = SEQ_4B;
          s.cp = {{(CP_BITS-3){1'b0}}, data_byte[2:0]};
          s.tent_err = 1'b0; lp = byte_count;
        end else begin
          s.err = 1'b1; ep = byte_count;
        end
      end else begin
        // first non-continuation byte inside a sequence stays tentative
        if (!seq.tent_err && data_byte[7:6] != CONT_TAG) begin
          s.tent_err = 1'b1; ep = byte_count;
        end
        s.cp   = cp_n;
        s.need = need_n;
        if (need_n == SEQ_NONE) begin
          if (s.tent_err) begin
            s.err = 1'b1;
          end else if (bad_cp) begin
            s.err = 1'b1; ep = lead_pos;
          end
        end
      end
    end
    // truncation at end of buffer is reported at the lead
    if (last && !s.err && s.need != SEQ_NONE) begin
      s.err = 1'b1; ep = lp;
    end
  end

  assign ep_ext     = {{RES_OFF_BITS{1'b0}}, ep};
  assign res_ok     = !s.err;
  assign res_offset = s.err ? ep_ext[RES_OFF_BITS-1:0] : '0;

  // buffer end returns everything to reset
  assign seq_nxt        = last ? SEQ_RESET : s;
  assign lead_pos_nxt   = last ? '0 : lp;
  assign err_pos_nxt    = last ? '0 : ep;
  assign byte_count_nxt = last ? '0 : byte_count + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

endmodule

// File: design/suv_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suv_out_reg
// Verdict register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module suv_out_reg import suv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic                    ok,
  input  logic [RES_OFF_BITS-1:0] offset,
  output logic                    can_load,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [RES_OFF_BITS-1:0] out_tdata,
  output logic                    out_tuser
);

  logic                    vld_r,  vld_nxt;
  logic                    ok_r;
  logic [RES_OFF_BITS-1:0] off_r;

  assign can_load = !vld_r || out_tready;
  assign vld_nxt  = load ? 1'b1 : (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r  <= ok;
      off_r <= offset;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = off_r;
  assign out_tuser  = ok_r;

endmodule

// File: design/strict_utf8_stream_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_utf8_stream_validator_core
// Checks a byte stream for strict UTF-8, one verdict per buffer.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                  | tuser        | tlast
//  in_     | slave     | [7:0] data_byte        | -            | last
//  out_    | master    | [31:0] bad_offset      | [0] valid_res| -
//
//  One byte per cycle while in_tready is high; each byte is decoded in the cycle it is accepted.
//  A verdict appears on out_ the cycle after the byte with tlast.
//  in_tready drops only while a verdict waits and out_tready is low.
//  Synchronous active-low reset clears the sequence state and out_tvalid.
// ----------------------------------------------------------------------------
module strict_utf8_stream_validator_core import suv_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [7:0] data_byte
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [RES_OFF_BITS-1:0] out_tdata,  // [31:0] bad_offset
  output logic                    out_tuser   // [0] valid_res
);

  suv_seq_t               seq_r, seq_nxt;
  logic [OFFSET_BITS-1:0] byte_count_r, byte_count_nxt;
  logic [OFFSET_BITS-1:0] lead_pos_r, lead_pos_nxt;
  logic [OFFSET_BITS-1:0] err_pos_r, err_pos_nxt;
  logic                   res_ok;
  logic [RES_OFF_BITS-1:0] res_offset;
  logic                   can_load;
  logic                   in_xfer;

  assign in_tready = can_load;
  assign in_xfer   = in_tvalid && in_tready;

  suv_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
    .data_byte      (in_tdata),
    .last           (in_tlast),
    .seq            (seq_r),
    .byte_count     (byte_count_r),
    .lead_pos       (lead_pos_r),
    .err_pos        (err_pos_r),
    .seq_nxt        (seq_nxt),
    .byte_count_nxt (byte_count_nxt),
    .lead_pos_nxt   (lead_pos_nxt),
    .err_pos_nxt    (err_pos_nxt),
    .res_ok         (res_ok),
    .res_offset     (res_offset)
  );

  suv_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer && in_tlast),
    .ok         (res_ok),
    .offset     (res_offset),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // advance the sequence state on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SEQ_RESET;
      byte_count_r <= '0;
      lead_pos_r   <= '0;
      err_pos_r    <= '0;
    end else if (in_xfer) begin
      seq_r        <= seq_nxt;
      byte_count_r <= byte_count_nxt;
      lead_pos_r   <= lead_pos_nxt;
      err_pos_r    <= err_pos_nxt;
    end
  end

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> out_tvalid)
    else $error("no verdict after last byte");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> byte_count_r == '0 && seq_r == SEQ_RESET)
    else $error("state not cleared after buffer end");

  a_valid_has_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("valid verdict carries an offset");

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting verdict");

  a_open_seq_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r.need != SEQ_NONE |-> seq_r.need <= seq_r.seq_len && !seq_r.err)
    else $error("inconsistent open sequence");

endmodule

// File: test/strict_utf8_stream_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_utf8_stream_validator_core_tb
// Streams byte buffers through the UTF-8 validator and checks every verdict.
// A class tracks the decode state byte by byte and queues the verdict that
// each buffer must end in. Both stream sides idle at random, and one long
// receiver hold backs the core up until it stalls its input.
// ----------------------------------------------------------------------------
module strict_utf8_stream_validator_core_tb import suv_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                    valid;
    logic [RES_OFF_BITS-1:0] offset;
  } verdict_t;

  // Tracks the decode of the current buffer and holds the verdicts still due
  class utf8_verdict_board;
    logic [31:0]        byte_pos;
    logic [31:0]        lead_pos;
    logic [31:0]        err_pos;
    logic [1:0]         need;
    logic [1:0]         seq_len;
    logic [CP_BITS-1:0] cp_acc;
    logic               tent_err;
    logic               err;
    verdict_t           verdicts_due[$];
    int                 mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      byte_pos = '0;
      lead_pos = '0;
      err_pos  = '0;
      need     = SEQ_NONE;
      seq_len  = SEQ_NONE;
      cp_acc   = '0;
      tent_err = 1'b0;
      err      = 1'b0;
    endfunction

    // A bad continuation becomes final once the full length has arrived; else the code point is range-checked
    function void close_sequence();
      if (tent_err) begin
        err = 1'b1;
        return;
      end
      if ((seq_len == SEQ_2B && cp_acc < MIN_CP_2B) ||
          (seq_len == SEQ_3B && cp_acc < MIN_CP_3B) ||
          (seq_len == SEQ_4B && cp_acc < MIN_CP_4B) ||
          (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
          cp_acc > MAX_CP) begin
        err     = 1'b1;
        err_pos = lead_pos;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [1:0]         n;
      logic [CP_BITS-1:0] cp;
      verdict_t           v;
      if (!err) begin
        if (need == SEQ_NONE) begin
          n  = SEQ_NONE;
          cp = '0;
          if (!b[7]) begin
            n = SEQ_NONE;
          end else if (b[7:5] == 3'b110) begin
            n  = SEQ_2B;
            cp = CP_BITS'(b[4:0]);
          end else if (b[7:4] == 4'b1110) begin
            n  = SEQ_3B;
            cp = CP_BITS'(b[3:0]);
          end else if (b[7:3] == 5'b11110) begin
            n  = SEQ_4B;
            cp = CP_BITS'(b[2:0]);
          end else begin
            err     = 1'b1;
            err_pos = byte_pos;
          end
          if (n != SEQ_NONE) begin
            need     = n;
            seq_len  = n;
            cp_acc   = cp;
            lead_pos = byte_pos;
            tent_err = 1'b0;
          end
        end else begin
          // only the first non-continuation byte of a sequence counts
          if (!tent_err && b[7:6] != CONT_TAG) begin
            tent_err = 1'b1;
            err_pos  = byte_pos;
          end
          cp_acc = {cp_acc[CP_BITS-7:0], b[5:0]};
          need   = need - 2'd1;
          if (need == SEQ_NONE) close_sequence();
        end
      end
      byte_pos = byte_pos + 32'd1;
      if (last) begin
        // truncation outranks a pending bad continuation
        if (!err && need != SEQ_NONE) begin
          err     = 1'b1;
          err_pos = lead_pos;
        end
        v.valid  = !err;
        v.offset = err ? err_pos : '0;
        verdicts_due.push_back(v);
        clear_state();
      end
    endfunction

    function void check_verdict(logic valid, logic [RES_OFF_BITS-1:0] offset);
      verdict_t exp_v;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict: valid=%0b offset=%0d", $time, valid, offset);
        mismatches++;
        return;
      end
      exp_v = verdicts_due.pop_front();
      if (valid !== exp_v.valid) begin
        $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                 $time, exp_v.valid, valid);
        mismatches++;
      end
      if (offset !== exp_v.offset) begin
        $display("%0t: bad_offset mismatch: expected %0d, actual %0d",
                 $time, exp_v.offset, offset);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [7:0]              in_tdata;   // [7:0] data_byte
  logic                    in_tlast;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [RES_OFF_BITS-1:0] out_tdata;  // [31:0] bad_offset
  logic                    out_tuser;  // [0] valid_res

  utf8_verdict_board sb;
  logic [7:0]        buf_q[$];
  int unsigned       sent_bytes;
  int unsigned       cycles;
  int unsigned       hold_req;
  bit                burst;

  strict_utf8_stream_validator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Encode cp in len bytes; len 0 picks the shortest form
  function automatic void put_cp(int unsigned cp, int len);
    logic [20:0] c;
    c = cp[20:0];
    if (len == 0) len = (cp < 32'h80) ? 1 : (cp < 32'h800) ? 2 : (cp < 32'h10000) ? 3 : 4;
    case (len)
      1: buf_q.push_back({1'b0, c[6:0]});
      2: begin
        buf_q.push_back({3'b110, c[10:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
      3: begin
        buf_q.push_back({4'b1110, c[15:12]});
        buf_q.push_back({2'b10, c[11:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
      default: begin
        buf_q.push_back({5'b11110, c[20:18]});
        buf_q.push_back({2'b10, c[17:12]});
        buf_q.push_back({2'b10, c[11:6]});
        buf_q.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  function automatic int unsigned any_multibyte_cp();
    int unsigned cp;
    cp = $urandom_range(32'h10FFFF, 32'h80);
    if (cp >= 32'hD800 && cp <= 32'hDFFF) cp += 32'h800;
    return cp;
  endfunction

  function automatic void add_char(bit faulty);
    int unsigned kind;
    int unsigned cp;
    int unsigned len;
    int unsigned start;
    logic [7:0]  nb;
    int unsigned edge_cps[9] = '{32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF,
                                 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF};
    kind  = faulty ? $urandom_range(13, 6) : $urandom_range(5, 0);
    start = buf_q.size();
    case (kind)
      0, 1: put_cp($urandom_range(127, 0), 1);
      2: put_cp($urandom_range(32'h7FF, 32'h80), 2);
      3: begin
        cp = $urandom_range(32'hFFFF, 32'h800);
        if (cp >= 32'hD800 && cp <= 32'hDFFF) cp ^= 32'h2000;
        put_cp(cp, 3);
      end
      4: put_cp($urandom_range(32'h10FFFF, 32'h10000), 4);
      5: put_cp(edge_cps[$urandom_range(8, 0)], 0);
      6: begin
        // overlong form
        len = $urandom_range(4, 2);
        cp  = (len == 2) ? 32'h80 : (len == 3) ? 32'h800 : 32'h10000;
        put_cp($urandom_range(cp - 1, 0), len);
      end
      7: put_cp($urandom_range(32'hDFFF, 32'hD800), 3);
      8: put_cp($urandom_range(32'h1FFFFF, 32'h110000), 4);
      9: begin
        // drop the tail of a sequence
        put_cp(any_multibyte_cp(), 0);
        len = buf_q.size() - start;
        repeat ($urandom_range(len - 1, 1)) void'(buf_q.pop_back());
      end
      10: begin
        // corrupt one continuation byte
        put_cp(any_multibyte_cp(), 0);
        len = buf_q.size() - start;
        nb  = $urandom_range(255, 0);
        if (nb[7:6] == CONT_TAG) nb[6] = 1'b1;
        buf_q[start + $urandom_range(len - 1, 1)] = nb;
      end
      11: buf_q.push_back({CONT_TAG, 6'($urandom_range(63, 0))});
      12: buf_q.push_back(8'($urandom_range(255, 248)));
      default: buf_q.push_back(8'($urandom_range(255, 0)));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++) send_byte(buf_q[i], i == buf_q.size() - 1);
    buf_q.delete();
  endtask

  task automatic random_buffer();
    int unsigned nchars;
    int unsigned bad_at;
    int unsigned mode;
    nchars = $urandom_range(8, 1);
    mode   = $urandom_range(99, 0);
    bad_at = (mode < 70) ? nchars : $urandom_range(nchars - 1, 0);
    if (mode >= 95) begin
      // raw noise
      repeat (nchars) buf_q.push_back(8'($urandom_range(255, 0)));
    end else begin
      for (int i = 0; i < nchars; i++) add_char(i == bad_at);
    end
    send_buffer();
  endtask

  task automatic drain_verdicts();
    int unsigned gap;
    forever begin
      gap      = (hold_req > 0) ? hold_req : (burst ? 0 : $urandom_range(19, 0));
      hold_req = 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_verdict(out_tuser, out_tdata);
      @(negedge clk);
    end
  endtask

  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    burst      = 1'b0;
    hold_req   = 0;
    sent_bytes = 0;
    cycles     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      drain_verdicts();
    join_none

    // shortest and longest valid forms
    buf_q = '{8'h00};
    send_buffer();
    buf_q = '{8'h7F, 8'hDF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_buffer();
    // lone continuation, then bytes absorbed until last
    buf_q = '{8'h41, 8'h80, 8'hFF};
    send_buffer();
    buf_q = '{8'hF8};
    send_buffer();
    // overlong, surrogate, above the code space
    buf_q = '{8'hC0, 8'h80};
    send_buffer();
    buf_q = '{8'hED, 8'hA0, 8'h80};
    send_buffer();
    buf_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_buffer();
    // bad continuation reported at its own offset
    buf_q = '{8'hE2, 8'h41, 8'h82};
    send_buffer();
    // truncation wins over the bad continuation
    buf_q = '{8'hE2, 8'h41};
    send_buffer();

    while (sent_bytes < 170) random_buffer();
    burst = 1'b1;
    while (sent_bytes < 240) random_buffer();
    // long receiver hold while the sender keeps offering
    hold_req = 150;
    while (sent_bytes < 320) random_buffer();
    burst = 1'b0;
    while (sent_bytes < 476) random_buffer();
    in_tvalid <= 1'b0;

    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/suv_pkg.sv
design/suv_step.sv
design/suv_out_reg.sv
design/strict_utf8_stream_validator_core.sv
test/strict_utf8_stream_validator_core_tb.sv
